// File: rtl/core/assert_macros.svh
// assertion macros used by the codec top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// an antecedent that forces a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/onkc_pkg.sv
// types, constants and helpers for the ordered numeric key codec
package onkc_pkg;

    localparam logic [2:0] CMD_INT_TO_KEY    = 3'd0;
    localparam logic [2:0] CMD_KEY_TO_INT    = 3'd1;
    localparam logic [2:0] CMD_DOUBLE_TO_KEY = 3'd2;
    localparam logic [2:0] CMD_KEY_TO_DOUBLE = 3'd3;
    localparam logic [2:0] CMD_FLOAT_TO_KEY  = 3'd4;
    localparam logic [2:0] CMD_KEY_TO_FLOAT  = 3'd5;

    localparam logic [63:0] KEY_BIAS64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] KEY_BIAS32 = 32'h8000_0000;

    // biased exponent of a value whose top set bit is bit 63
    localparam logic [10:0] EXP_TOP    = 11'd1086;
    // biased exponent of one
    localparam logic [10:0] EXP_ONE    = 11'd1023;

    // one pipeline stage: integer-to-key path, key-to-int path, simple result
    typedef struct packed {
        logic [2:0]  cmd;
        logic        neg;
        logic        mzero;
        logic [5:0]  lz;
        logic [63:0] word;
        logic [63:0] simple;
        logic        kbelow;
        logic        ksat;
        logic        ksmall;
        logic [5:0]  ksh;
        logic [63:0] kword;
    } stage_t;

    // leading zero count by halving, six steps
    function automatic logic [6:0] clz64(input logic [63:0] v);
        logic [63:0] x;
        logic [6:0]  n;
        x = v;
        n = 7'd0;
        if (v == 64'd0)
        begin
            n = 7'd64;
        end
        else
        begin
            if (x[63:32] == 32'd0) begin n = n + 7'd32; x = {x[31:0], 32'd0}; end
            if (x[63:48] == 16'd0) begin n = n + 7'd16; x = {x[47:0], 16'd0}; end
            if (x[63:56] == 8'd0)  begin n = n + 7'd8;  x = {x[55:0], 8'd0};  end
            if (x[63:60] == 4'd0)  begin n = n + 7'd4;  x = {x[59:0], 4'd0};  end
            if (x[63:62] == 2'd0)  begin n = n + 7'd2;  x = {x[61:0], 2'd0};  end
            if (x[63] == 1'b0)     begin n = n + 7'd1;  end
        end
        return n;
    endfunction

endpackage

// File: rtl/core/ordered_numeric_key_codec.sv
// top level of the ordered numeric key codec, a four-stage pipeline
//
// Converts between numbers and 64-bit unsigned keys whose unsigned order
// follows numeric order (sign-flip encoding of IEEE 754 patterns). cmd picks
// int64 to key (rounded to a double, nearest even), key to int64 (truncated,
// saturating, zero below one), double to key, key to double, float to key and
// key to float; the float modes use the low 32 bits and return the upper half
// zero, and cmd 6 or 7 returns zero. One word is accepted every cycle while
// in_stall is low. Each word passes through the four register stages in order:
// negate and decode, leading zero count and coarse right shift, normalizing
// left shift and fine right shift, then the 53-bit rounding add or the final
// negate. A stall on the output holds the pipeline in place, and bubbles
// collapse so in_stall rises only when every stage is full.
`include "assert_macros.svh"

module ordered_numeric_key_codec
    import onkc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [63:0] operand_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] result_bits
);

    // stage valid bits and payload
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    stage_t      s1_reg, s2_reg, s3_reg;
    stage_t      s1_next, s2_next, s3_next;
    logic [63:0] r4_reg, r4_next;

    // a stage moves when it is empty or the one after it moves
    logic adv4, adv3, adv2, adv1;

    assign adv4 = !v4_reg || !out_stall;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign in_stall    = !adv1;
    assign out_valid   = v4_reg;
    assign result_bits = r4_reg;

    // stage 1: magnitude, key decode, the plain bit-flip modes
    logic [62:0] cov;
    logic [10:0] kexp;
    logic [10:0] kshift;

    always_comb
    begin
        s1_next        = '0;
        s1_next.cmd    = cmd;
        s1_next.neg    = operand_bits[63];
        s1_next.word   = operand_bits[63] ? (~operand_bits + 64'd1) : operand_bits;
        s1_next.mzero  = (operand_bits == 64'd0);

        // magnitude field of the key relative to the bias
        cov            = operand_bits[63] ? operand_bits[62:0] : ~operand_bits[62:0];
        kexp           = cov[62:52];
        kshift         = EXP_TOP - kexp;
        s1_next.kbelow = !operand_bits[63];
        s1_next.ksat   = (kexp >= EXP_TOP);
        s1_next.ksmall = (kexp < EXP_ONE);
        s1_next.ksh    = kshift[5:0];
        s1_next.kword  = {1'b1, cov[51:0], 11'd0};

        unique case (cmd)
            CMD_DOUBLE_TO_KEY:
                s1_next.simple = operand_bits[63] ? ~operand_bits
                                                  : (operand_bits ^ KEY_BIAS64);
            CMD_KEY_TO_DOUBLE:
                s1_next.simple = operand_bits[63] ? (operand_bits ^ KEY_BIAS64)
                                                  : ~operand_bits;
            CMD_FLOAT_TO_KEY:
                s1_next.simple = {32'd0, operand_bits[31] ? ~operand_bits[31:0]
                                                          : (operand_bits[31:0] ^ KEY_BIAS32)};
            CMD_KEY_TO_FLOAT:
                s1_next.simple = {32'd0, operand_bits[31] ? (operand_bits[31:0] ^ KEY_BIAS32)
                                                          : ~operand_bits[31:0]};
            default:
                s1_next.simple = 64'd0;
        endcase
    end

    // stage 2: leading zeros of the magnitude, coarse right shift of the key
    logic [6:0] lz_full;

    always_comb
    begin
        s2_next       = s1_reg;
        lz_full       = clz64(s1_reg.word);
        s2_next.lz    = lz_full[5:0];
        s2_next.kword = s1_reg.kword >> {s1_reg.ksh[5:3], 3'b000};
    end

    // stage 3: normalize so the top set bit lands on bit 63, fine right shift
    always_comb
    begin
        s3_next       = s2_reg;
        s3_next.word  = s2_reg.word << s2_reg.lz;
        s3_next.kword = s2_reg.kword >> s2_reg.ksh[2:0];
    end

    // stage 4: round to 53 bits and pack the key, or finish the integer
    logic        round_up;
    logic [53:0] sig;
    logic        sig_ovf;
    logic [10:0] expo;
    logic [51:0] frac;
    logic [62:0] body;
    logic [63:0] int_key;
    logic [63:0] int_val;

    always_comb
    begin
        // round bit is bit 10, sticky below it, lsb bit 11
        round_up = s3_reg.word[10] && ((s3_reg.word[9:0] != 10'd0) || s3_reg.word[11]);
        sig      = {1'b0, s3_reg.word[63:11]} + {53'd0, round_up};
        sig_ovf  = sig[53];
        expo     = EXP_TOP - {5'd0, s3_reg.lz} + {10'd0, sig_ovf};
        frac     = sig_ovf ? 52'd0 : sig[51:0];
        body     = {expo, frac};

        if (s3_reg.mzero)
        begin
            int_key = KEY_BIAS64;
        end
        else if (s3_reg.neg)
        begin
            int_key = {1'b0, ~body};
        end
        else
        begin
            int_key = {1'b1, body};
        end

        if (s3_reg.ksat)
        begin
            int_val = s3_reg.kbelow ? KEY_BIAS64 : INT_MAX64;
        end
        else if (s3_reg.ksmall)
        begin
            int_val = 64'd0;
        end
        else
        begin
            int_val = s3_reg.kbelow ? (~s3_reg.kword + 64'd1) : s3_reg.kword;
        end

        unique case (s3_reg.cmd)
            CMD_INT_TO_KEY: r4_next = int_key;
            CMD_KEY_TO_INT: r4_next = int_val;
            default:        r4_next = s3_reg.simple;
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // payload, held while the stage does not move
    always_ff @(posedge clk)
    begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) s3_reg <= s3_next;
        if (adv4) r4_reg <= r4_next;
    end

    // checks
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall, v1_reg,
        "accepted word did not reach stage 1")
    `ASSERT_NEXT(a_s2_holds, clk, rst_n, v2_reg && !adv3, v2_reg && $stable(s2_reg),
        "stage 2 changed while blocked")
    `ASSERT_ALWAYS(a_norm_top_bit, clk, rst_n,
        !(v3_reg && (s3_reg.cmd == CMD_INT_TO_KEY) && !s3_reg.mzero) || s3_reg.word[63],
        "normalized magnitude lacks its top bit")

endmodule
